@@ src/hti_pkg.sv @@
// ---------------------------------------------------------------------------
// hti_pkg: shared types and constants for the hermite table interpolator
// Holds the action and status codes, the sequencer states, the multiply step
// codes and the Q16.16 saturation helpers.
// ---------------------------------------------------------------------------
package hti_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ENTRY_W     = 96;

	// action codes carried in tuser of the input stream
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// status codes carried in tuser of the output stream
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_RANGE = 2'd1;
	localparam logic [1:0] STATUS_FEW   = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD0,
		ST_RDL,
		ST_CHK,
		ST_BIS,
		ST_BISW,
		ST_FHI,
		ST_GOT,
		ST_DIFF,
		ST_PREP,
		ST_DIV,
		ST_SIGN,
		ST_MULA,
		ST_MULB,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MS_U2,
		MS_U3,
		MS_P,
		MS_Q,
		MS_UD,
		MS_A,
		MS_B,
		MS_C
	} mul_step_t;

	// sign extension to 64 bits
	function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
		sx64 = {{32{v[31]}}, v};
	endfunction

	// clamp to signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	// magnitude of a signed 32-bit value
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		mag32 = v[31] ? 32'(-v) : 32'(v);
	endfunction

endpackage

@@ src/hti_ram.sv @@
// ---------------------------------------------------------------------------
// hti_ram: generic single-port synchronous ram
// One write or one read per cycle, read data registered.
// ---------------------------------------------------------------------------
module hti_ram #(
	parameter int WIDTH = hti_pkg::ENTRY_W,
	parameter int DEPTH = hti_pkg::TABLE_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ src/hermite_table_interpolator_unit.sv @@
// ---------------------------------------------------------------------------
// hermite_table_interpolator_unit: cubic hermite interpolation over a table
// Knot table in one ram, bisection search, serial divider, shared multiplier.
// ---------------------------------------------------------------------------
// A load item (tuser = 0) writes one knot (position, value, slope) into the
// table as it is accepted. A query item (tuser = 1) runs at most ceil(log2(n))
// bisection steps over the n knots in use: every bisection step is a read of
// the single-port table ram plus a compare, the position ratio goes through a
// serial restoring divider, and eight products share one 32x32 multiplier,
// each through a multiply state and a write-back state. A query with fewer
// than two knots goes straight to the output state, one outside the table
// after the end reads and the range check. One item is worked on at a time;
// the result sits in an output register so the next item is taken while it
// waits. Reading a table entry that was never loaded gives an undefined result.
// ---------------------------------------------------------------------------
module hermite_table_interpolator_unit #(
	parameter int TABLE_DEPTH = hti_pkg::TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	// config
	input  logic         cfg_we,
	input  logic [10:0]  cfg_wdata,       // point_count
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// point_index[9:0], knot_position[41:10], knot_value[73:42],
	// knot_slope[105:74], query_position[137:106], zero pad
	input  logic [143:0] s_axis_tdata,
	input  logic         s_axis_tuser,    // action
	// output stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata,    // interpolated_value
	output logic [1:0]   m_axis_tuser     // status
);

	localparam int AW = $clog2(TABLE_DEPTH);

	hti_pkg::state_t    state_q, state_d;
	hti_pkg::mul_step_t step_q;

	logic [10:0] point_count_q;
	logic [31:0] n_cnt;
	logic [AW-1:0] n_last;

	logic        accept;
	logic        ram_we;
	logic [AW-1:0] ram_addr;
	logic [hti_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

	logic [9:0]         in_index;
	logic signed [31:0] in_pos, in_val, in_slope, in_query;

	logic signed [31:0] z_q, rd_pos;
	logic               below_q;
	logic [AW-1:0]      lo_q, hi_q, mid_q, mid;
	logic [AW:0]        mid_sum;
	logic               bis_more;

	logic signed [31:0] x1_q, y1_q, s1_q, x2_q, y2_q, s2_q;
	logic signed [31:0] dx_q, dy_q, t_q;
	logic signed [31:0] ss_q, sw_q, dy2_q, dy3_q;
	logic signed [31:0] u_q, u2_q, u3_q, ud_q, yb2_q, yb4_q;
	logic signed [63:0] acc_q;

	logic [31:0]  rem_q, div_q;
	logic [47:0]  dvd_q;
	logic [5:0]   dcnt_q;
	logic         dneg_q;
	logic [32:0]  dshift;
	logic         dfit;

	logic signed [31:0] op_a, op_b, mres;
	logic signed [63:0] prod_q;

	logic signed [31:0] res_q;
	logic [1:0]         stat_q;
	logic               out_free;

	// input field unpacking
	assign in_index = s_axis_tdata[9:0];
	assign in_pos   = s_axis_tdata[41:10];
	assign in_val   = s_axis_tdata[73:42];
	assign in_slope = s_axis_tdata[105:74];
	assign in_query = s_axis_tdata[137:106];

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	// knots in use, clamped to the table depth
	assign n_cnt  = (32'(point_count_q) > 32'(TABLE_DEPTH)) ?
		32'(TABLE_DEPTH) : 32'(point_count_q);
	assign n_last = AW'(n_cnt - 32'd1);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	// knot table
	assign ram_wdata = {in_slope, in_val, in_pos};
	assign rd_pos    = ram_rdata[31:0];

	hti_ram #(
		.WIDTH(hti_pkg::ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// bisection midpoint
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[AW:1];
	assign bis_more = AW'(hi_q - lo_q) > AW'(1);

	// divider step
	assign dshift = {rem_q, dvd_q[47]};
	assign dfit   = dshift >= {1'b0, div_q};

	// multiplier operand select
	always_comb begin
		case (step_q)
			hti_pkg::MS_U2: begin op_a = u_q;  op_b = u_q;  end
			hti_pkg::MS_U3: begin op_a = u2_q; op_b = u_q;  end
			hti_pkg::MS_P:  begin op_a = dx_q; op_b = ss_q; end
			hti_pkg::MS_Q:  begin op_a = dx_q; op_b = sw_q; end
			hti_pkg::MS_UD: begin op_a = u_q;  op_b = dx_q; end
			hti_pkg::MS_A:  begin op_a = ud_q; op_b = s1_q; end
			hti_pkg::MS_B:  begin op_a = u2_q; op_b = yb4_q; end
			hti_pkg::MS_C:  begin op_a = u3_q; op_b = yb2_q; end
			default:        begin op_a = u_q;  op_b = u_q;  end
		endcase
	end

	// floor of product over 2^16, saturated
	assign mres = hti_pkg::sat32(prod_q >>> 16);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hti_pkg::ST_IDLE: begin
				if (accept && s_axis_tuser == hti_pkg::ACT_QUERY) begin
					state_d = (n_cnt < 32'd2) ? hti_pkg::ST_OUT : hti_pkg::ST_RD0;
				end
			end
			hti_pkg::ST_RD0:  state_d = hti_pkg::ST_RDL;
			hti_pkg::ST_RDL:  state_d = hti_pkg::ST_CHK;
			hti_pkg::ST_CHK: begin
				state_d = (below_q || z_q > rd_pos) ? hti_pkg::ST_OUT : hti_pkg::ST_BIS;
			end
			hti_pkg::ST_BIS:  state_d = bis_more ? hti_pkg::ST_BISW : hti_pkg::ST_FHI;
			hti_pkg::ST_BISW: state_d = hti_pkg::ST_BIS;
			hti_pkg::ST_FHI:  state_d = hti_pkg::ST_GOT;
			hti_pkg::ST_GOT:  state_d = hti_pkg::ST_DIFF;
			hti_pkg::ST_DIFF: state_d = hti_pkg::ST_PREP;
			hti_pkg::ST_PREP: state_d = (dx_q == 32'sd0) ? hti_pkg::ST_OUT : hti_pkg::ST_DIV;
			hti_pkg::ST_DIV:  state_d = (dcnt_q == 6'd47) ? hti_pkg::ST_SIGN : hti_pkg::ST_DIV;
			hti_pkg::ST_SIGN: state_d = hti_pkg::ST_MULA;
			hti_pkg::ST_MULA: state_d = hti_pkg::ST_MULB;
			hti_pkg::ST_MULB: begin
				state_d = (step_q == hti_pkg::MS_C) ? hti_pkg::ST_FIN : hti_pkg::ST_MULA;
			end
			hti_pkg::ST_FIN:  state_d = hti_pkg::ST_OUT;
			hti_pkg::ST_OUT:  state_d = out_free ? hti_pkg::ST_IDLE : hti_pkg::ST_OUT;
			default:          state_d = hti_pkg::ST_IDLE;
		endcase
	end

	// handshake and table port control
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_addr      = '0;
		case (state_q)
			hti_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				ram_we   = accept && s_axis_tuser == hti_pkg::ACT_LOAD &&
					32'(in_index) < 32'(TABLE_DEPTH);
				ram_addr = AW'(in_index);
			end
			hti_pkg::ST_RDL: ram_addr = n_last;
			hti_pkg::ST_BIS: ram_addr = bis_more ? mid : lo_q;
			hti_pkg::ST_FHI: ram_addr = hi_q;
			default:         ram_addr = '0;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hti_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == hti_pkg::ST_OUT && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == hti_pkg::ST_OUT && out_free) begin
			m_axis_tdata <= res_q;
			m_axis_tuser <= stat_q;
		end
	end

	// multiply step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= hti_pkg::MS_U2;
		end else if (state_q == hti_pkg::ST_SIGN) begin
			step_q <= hti_pkg::MS_U2;
		end else if (state_q == hti_pkg::ST_MULB && step_q != hti_pkg::MS_C) begin
			step_q <= hti_pkg::mul_step_t'(step_q + 3'd1);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			hti_pkg::ST_IDLE: begin
				z_q    <= in_query;
				res_q  <= '0;
				stat_q <= hti_pkg::STATUS_FEW;
			end
			hti_pkg::ST_RDL: begin
				below_q <= z_q < rd_pos;
			end
			hti_pkg::ST_CHK: begin
				stat_q <= hti_pkg::STATUS_RANGE;
				lo_q   <= '0;
				hi_q   <= n_last;
			end
			hti_pkg::ST_BIS: begin
				mid_q <= mid;
			end
			hti_pkg::ST_BISW: begin
				if (z_q < rd_pos) begin
					hi_q <= mid_q;
				end else if (z_q > rd_pos) begin
					lo_q <= mid_q;
				end else begin
					lo_q <= mid_q;
					hi_q <= mid_q + AW'(1);
				end
			end
			hti_pkg::ST_FHI: begin
				x1_q <= ram_rdata[31:0];
				y1_q <= ram_rdata[63:32];
				s1_q <= ram_rdata[95:64];
			end
			hti_pkg::ST_GOT: begin
				x2_q <= ram_rdata[31:0];
				y2_q <= ram_rdata[63:32];
				s2_q <= ram_rdata[95:64];
			end
			hti_pkg::ST_DIFF: begin
				dx_q <= hti_pkg::sat32(hti_pkg::sx64(x2_q) - hti_pkg::sx64(x1_q));
				dy_q <= hti_pkg::sat32(hti_pkg::sx64(y2_q) - hti_pkg::sx64(y1_q));
				t_q  <= hti_pkg::sat32(hti_pkg::sx64(z_q) - hti_pkg::sx64(x1_q));
			end
			hti_pkg::ST_PREP: begin
				// zero spacing returns the left value
				res_q  <= y1_q;
				stat_q <= hti_pkg::STATUS_OK;
				ss_q   <= hti_pkg::sat32(hti_pkg::sx64(s1_q) + hti_pkg::sx64(s2_q));
				sw_q   <= hti_pkg::sat32(hti_pkg::sx64(s2_q) + 2 * hti_pkg::sx64(s1_q));
				dy2_q  <= hti_pkg::sat32(-2 * hti_pkg::sx64(dy_q));
				dy3_q  <= hti_pkg::sat32(3 * hti_pkg::sx64(dy_q));
				acc_q  <= hti_pkg::sx64(y1_q);
				rem_q  <= '0;
				div_q  <= hti_pkg::mag32(dx_q);
				dvd_q  <= {hti_pkg::mag32(t_q), 16'h0000};
				dneg_q <= t_q[31] ^ dx_q[31];
				dcnt_q <= '0;
			end
			hti_pkg::ST_DIV: begin
				// one quotient bit per cycle
				rem_q  <= dfit ? 32'(dshift - {1'b0, div_q}) : dshift[31:0];
				dvd_q  <= {dvd_q[46:0], dfit};
				dcnt_q <= dcnt_q + 6'd1;
			end
			hti_pkg::ST_SIGN: begin
				if (!dneg_q) begin
					u_q <= (dvd_q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(dvd_q);
				end else begin
					u_q <= (dvd_q > 48'h0000_8000_0000) ? 32'sh8000_0000 : 32'(-dvd_q);
				end
			end
			hti_pkg::ST_MULA: begin
				prod_q <= hti_pkg::sx64(op_a) * hti_pkg::sx64(op_b);
			end
			hti_pkg::ST_MULB: begin
				case (step_q)
					hti_pkg::MS_U2: u2_q <= mres;
					hti_pkg::MS_U3: u3_q <= mres;
					hti_pkg::MS_P:  yb2_q <= hti_pkg::sat32(hti_pkg::sx64(dy2_q) +
						hti_pkg::sx64(mres));
					hti_pkg::MS_Q:  yb4_q <= hti_pkg::sat32(hti_pkg::sx64(dy3_q) -
						hti_pkg::sx64(mres));
					hti_pkg::MS_UD: ud_q <= mres;
					default:        acc_q <= acc_q + hti_pkg::sx64(mres);
				endcase
			end
			hti_pkg::ST_FIN: begin
				res_q <= hti_pkg::sat32(acc_q);
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/hti_checker.sv @@
// ---------------------------------------------------------------------------
// hti_checker: port-level checks for the hermite table interpolator
// Watches the streams and flags protocol or result-code slips.
// ---------------------------------------------------------------------------
module hti_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [31:0]  m_axis_tdata,
	input logic [1:0]   m_axis_tuser
);

	// a stalled result item stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped while stalled");

	// only defined status codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == hti_pkg::STATUS_OK ||
			m_axis_tuser == hti_pkg::STATUS_RANGE || m_axis_tuser == hti_pkg::STATUS_FEW))
		else $error("undefined status code");

	// error results carry zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != hti_pkg::STATUS_OK |-> m_axis_tdata == 32'd0)
		else $error("error result not zero");

	// a query holds off the input in the cycle after it is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == hti_pkg::ACT_QUERY
		|=> !s_axis_tready)
		else $error("input taken while query in flight");

endmodule

bind hermite_table_interpolator_unit hti_checker u_hti_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
